// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/smf_pkg.sv -----
package smf_pkg;

  localparam int MAX_HALF    = 7;
  localparam int SAMPLE_BITS = 32;
  localparam int HALF_BITS   = 3;
  localparam int HALF_RESET  = 2;
  localparam int DEPTH       = 2 * MAX_HALF + 1;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int IDX_BITS    = $clog2(DEPTH);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [HALF_BITS-1:0]   half_t;

  // Word passed from one sort cell to the next.
  typedef struct packed {
    logic    valid;
    logic    after;  // incoming sample belongs at or before this cell
    sample_t value;
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FEED,
    S_PICK,
    S_SUM
  } state_t;

  // Clamp the configured half width to what the store can hold.
  function automatic cnt_t eff_half(input half_t h);
    if (int'(h) > MAX_HALF) begin
      return CNT_BITS'(MAX_HALF);
    end
    return CNT_BITS'(h);
  endfunction

endpackage

// ----- rtl/smf_in_if.sv -----
interface smf_in_if import smf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// ----- rtl/smf_out_if.sv -----
interface smf_out_if import smf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median_value;
  logic    last_result;

  modport source (output valid, output median_value, output last_result, input ready);
  modport sink (input valid, input median_value, input last_result, output ready);
endinterface

// ----- rtl/smf_cfg_if.sv -----
interface smf_cfg_if import smf_pkg::*; ();
  logic  valid;
  logic  ready;
  half_t half_width;

  modport source (output valid, output half_width, input ready);
  modport sink (input valid, input half_width, output ready);
endinterface

// ----- rtl/sliding_median_filter_1d.sv -----
// Sliding median filter over a stream of unsigned counts.
// stream: sample words in, last_sample marks the end of a stream.
// result: one median word per input sample, last_result on the final one.
// cfg: half_width write port, always ready; write it only while idle.
// Result i is the median of samples i-h .. i+h, cut short at both stream
// ends; an even-length window gives the floor of the mean of its middle pair.
// Result i leaves once sample i+h has been taken; the last sample flushes
// every result still pending, so one sample may release up to h+1 words,
// or up to MAX_HALF+1 (8) right after half_width has been made smaller.
// A sample is taken in S_IDLE and checked in the next cycle, in S_CHECK.
// Each released word then passes a setup step (S_CHECK), the insertion of
// its n window samples (n up to 2h+1) through the sorting chain, a select
// step and the load of the output register. The sorting chain is the
// bottleneck.
// A stalled receiver holds the output register; the block then waits in
// its output stage and takes no new sample until the word is gone.
// Reset: half_width returns to 2, all counts clear, no result pending.
module sliding_median_filter_1d import smf_pkg::*; (
  input logic        clk,
  input logic        rst,
  smf_in_if.sink     stream,
  smf_out_if.source  result,
  smf_cfg_if.sink    cfg
);
`include "assert_macros.svh"

  state_t  state, state_next;
  half_t   half_width;
  sample_t store [DEPTH];
  cnt_t    rc, pc, h_w, n_r;
  logic    last_w;
  idx_t    idx, hi_r;
  sample_t mid_a, mid_b;
  logic    out_valid;
  sample_t out_data;
  logic    out_last;

  logic    accept, out_free, go;
  cnt_t    rc_inc, pc_inc, pc_new;
  cnt_t    d, lo, hi, rc_m1, n, sel_a, sel_b;
  logic [CNT_BITS:0]    hi_full;
  logic [SAMPLE_BITS:0] pair_sum;

  link_t   links [DEPTH+1];
  sample_t chain_val [DEPTH];
  logic [DEPTH-1:0] chain_valid;
  logic    chain_clear, chain_ins;
  sample_t feed_x;

  assign cfg.ready    = 1'b1;
  assign stream.ready = (state == S_IDLE);
  assign accept       = stream.valid && stream.ready;
  assign out_free     = !out_valid || result.ready;

  assign result.valid        = out_valid;
  assign result.median_value = out_data;
  assign result.last_result  = out_last;

  // Counts after taking a sample; pending never exceeds received.
  assign rc_inc = (rc == CNT_BITS'(DEPTH)) ? rc : rc + 1'b1;
  assign pc_inc = (pc == CNT_BITS'(DEPTH)) ? pc : pc + 1'b1;
  assign pc_new = (pc_inc > rc_inc) ? rc_inc : pc_inc;

  // Window of the oldest pending sample, offset d from the newest.
  assign go      = last_w ? (pc != '0) : (pc > h_w);
  assign d       = pc - 1'b1;
  assign lo      = (d > h_w) ? d - h_w : '0;
  assign hi_full = {1'b0, d} + {1'b0, h_w};
  assign rc_m1   = rc - 1'b1;
  assign hi      = (hi_full > {1'b0, rc_m1}) ? rc_m1 : hi_full[CNT_BITS-1:0];
  assign n       = hi - lo + 1'b1;

  // Middle pair of the sorted window; odd lengths pick the same cell twice.
  assign sel_a    = (n_r - 1'b1) >> 1;
  assign sel_b    = n_r >> 1;
  assign pair_sum = {1'b0, mid_a} + {1'b0, mid_b};

  assign chain_clear = (state == S_CHECK);
  assign chain_ins   = (state == S_FEED);
  assign feed_x      = store[idx];
  assign links[0]    = '0;

  // Insertion sort chain: one window sample enters per cycle.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    smf_sort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .clear (chain_clear),
      .ins   (chain_ins),
      .x     (feed_x),
      .prev  (links[g]),
      .link  (links[g+1])
    );
    assign chain_val[g]   = links[g+1].value;
    assign chain_valid[g] = links[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = go ? S_FEED : S_IDLE;
      end
      S_FEED: begin
        if (idx == hi_r) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          state_next = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_BITS'(HALF_RESET);
      rc         <= '0;
      pc         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        half_width <= cfg.half_width;
      end
      if (accept) begin
        rc <= rc_inc;
        pc <= pc_new;
      end
      // end of stream: drop the counts once every word is out
      if (state == S_CHECK && !go && last_w) begin
        rc <= '0;
        pc <= '0;
      end
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
        pc        <= pc - 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      store[0] <= stream.sample;
      for (int i = 1; i < DEPTH; i++) begin
        store[i] <= store[i-1];
      end
      h_w    <= eff_half(half_width);
      last_w <= stream.last_sample;
    end
    if (state == S_CHECK && go) begin
      idx  <= lo[IDX_BITS-1:0];
      hi_r <= hi[IDX_BITS-1:0];
      n_r  <= n;
    end
    if (state == S_FEED) begin
      idx <= idx + 1'b1;
    end
    if (state == S_PICK) begin
      mid_a <= chain_val[sel_a[IDX_BITS-1:0]];
      mid_b <= chain_val[sel_b[IDX_BITS-1:0]];
    end
    if (state == S_SUM && out_free) begin
      out_data <= pair_sum[SAMPLE_BITS:1];
      out_last <= last_w && (pc == CNT_BITS'(1));
    end
  end

  `ASSERT_CLK(a_pend_le_recv, clk, rst, pc <= rc, "pending count exceeds received count")
  `ASSERT_CLK(a_pend_bound, clk, rst, pc <= CNT_BITS'(MAX_HALF + 1), "pending count out of range")
  `ASSERT_CLK(a_take_check, clk, rst, accept |=> state == S_CHECK, "accepted word not checked")
  `ASSERT_CLK(a_feed_range, clk, rst, state == S_FEED |-> idx <= hi_r, "feed index beyond window")
  `ASSERT_CLK(a_chain_fill, clk, rst, state == S_PICK |-> $countones(chain_valid) == int'(n_r), "sort chain fill differs from window length")

endmodule

// ----- rtl/smf_sort_cell.sv -----
module smf_sort_cell import smf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    clear,
  input  logic    ins,
  input  sample_t x,
  input  link_t   prev,
  output link_t   link
);

  logic    valid;
  sample_t value;

  assign link.valid = valid;
  assign link.value = value;
  assign link.after = !valid || (value > x);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (prev.after) begin
        // left neighbour moves right to make room
        valid <= prev.valid;
      end else if (link.after) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (prev.after) begin
        value <= prev.value;
      end else if (link.after) begin
        value <= x;
      end
    end
  end

endmodule

// ----- verif/tb_sliding_median_filter_1d.sv -----
`timescale 1ns / 1ps

module tb_sliding_median_filter_1d;
  import smf_pkg::*;

  // Cycles to let pass after the last expected word before the block counts
  // as idle: a sample that releases nothing still passes the check stage,
  // so leave a generous margin over the sorting chain length.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int RANDOM_ITEMS  = 75;
  localparam int MAX_RELEASE   = 8;
  // Row marker: work the expected words out with the predictor.
  localparam int PREDICT       = -1;

  typedef enum logic {
    ROW_WORD,
    ROW_HALF
  } row_kind_t;

  typedef enum logic [1:0] {
    VAL_WIDE,
    VAL_NARROW,
    VAL_EDGE,
    VAL_MIXED
  } value_style_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_CHOPPY,
    RX_STALLS
  } rx_mode_t;

  // One directed step: either a sample word or a half-width write. Where the
  // expected words are obvious they are typed in (n_typed of them, the final
  // one carrying last_result when the row ends a stream).
  typedef struct packed {
    row_kind_t kind;
    half_t     half;
    sample_t   smp;
    logic      last;
    int        n_typed;
    sample_t   typed0;
    sample_t   typed1;
  } stim_row_t;

  typedef struct {
    sample_t median;
    logic    last;
  } median_word_t;

  localparam int N_DIRECTED = 28;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Reset half width of 2: single-sample streams give the sample back.
    '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1, 32'h0000_0000, '0},
    '{ROW_WORD, 3'd0, 32'hFFFF_FFFF, 1'b1, 1, 32'hFFFF_FFFF, '0},
    // Two all-ones samples: the mean of the middle pair must not overflow.
    '{ROW_WORD, 3'd0, 32'hFFFF_FFFF, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'hFFFF_FFFF, 1'b1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // Ordinary stream with cut windows at both ends.
    '{ROW_WORD, 3'd0, 32'h0000_0001, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'hFFFF_FFFE, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0007, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0003, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0003, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h8000_0000, 1'b1, PREDICT, '0, '0},
    // Smallest window: every sample is its own median.
    '{ROW_HALF, 3'd0, '0, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h1234_5678, 1'b0, 1, 32'h1234_5678, '0},
    '{ROW_WORD, 3'd0, 32'hA5A5_A5A5, 1'b1, 1, 32'hA5A5_A5A5, '0},
    // Widest window, then shrink it mid-stream with seven words owed.
    '{ROW_HALF, 3'd7, '0, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0009, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0002, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'hFFFF_FFFF, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0005, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0005, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0001, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'hC000_0000, 1'b0, PREDICT, '0, '0},
    '{ROW_HALF, 3'd0, '0, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0004, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0006, 1'b0, PREDICT, '0, '0},
    // Grow the window mid-stream, then flush.
    '{ROW_HALF, 3'd1, '0, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0002, 1'b0, PREDICT, '0, '0},
    '{ROW_WORD, 3'd0, 32'h0000_0010, 1'b1, PREDICT, '0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  smf_in_if  stream_if ();
  smf_out_if result_if ();
  smf_cfg_if cfg_if ();

  sliding_median_filter_1d u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Predictor state: the sample history (newest first), how many of those
  // belong to the running stream, how many of them still owe a median, and
  // the half width currently in force.
  sample_t win_hist [DEPTH];
  cnt_t    held_cnt;
  cnt_t    owed_cnt;
  half_t   half_cfg;

  median_word_t released [$];
  median_word_t median_q [$];
  median_word_t got;

  int err_cnt      = 0;
  int words_seen   = 0;
  int n_samples    = 0;
  int n_streams    = 0;
  int n_half_wr    = 0;
  int burst_left   = 0;

  // Median of history entries lo..hi; an even count takes the floor of the
  // mean of the middle pair, summed one bit wider.
  function automatic sample_t window_median(input int lo, input int hi);
    sample_t              sorted [DEPTH];
    logic [SAMPLE_BITS:0] pair_sum;
    int                   n;
    int                   j;
    n = 0;
    for (int i = lo; i <= hi; i++) begin
      j = n;
      while (j > 0 && sorted[j-1] > win_hist[i]) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = win_hist[i];
      n++;
    end
    if (n == 0) return '0;
    if (n % 2 == 1) return sorted[n/2];
    pair_sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
    return pair_sum[SAMPLE_BITS:1];
  endfunction

  // Take one sample into the predictor and collect the medians it releases,
  // oldest first, into 'released'.
  task automatic advance_filter(input sample_t s, input logic l);
    int h;
    int d;
    int lo;
    int hi;
    int floor_cnt;
    h = (int'(half_cfg) > MAX_HALF) ? MAX_HALF : int'(half_cfg);
    released.delete();
    for (int i = DEPTH - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
    win_hist[0] = s;
    if (held_cnt < DEPTH) held_cnt++;
    if (owed_cnt < DEPTH) owed_cnt++;
    if (owed_cnt > held_cnt) owed_cnt = held_cnt;
    // Mid-stream, keep the last h owed; at the end of a stream flush them all.
    floor_cnt = l ? 0 : h;
    while (int'(owed_cnt) > floor_cnt && released.size() < MAX_RELEASE) begin
      d  = int'(owed_cnt) - 1;
      lo = (d > h) ? d - h : 0;
      hi = (d + h > int'(held_cnt) - 1) ? int'(held_cnt) - 1 : d + h;
      released.insert(released.size(), '{window_median(lo, hi), l && owed_cnt == 1});
      owed_cnt--;
    end
    if (l) begin
      held_cnt = '0;
      owed_cnt = '0;
    end
  endtask

  // Drop valid and hold off until every expected word has come back, then
  // give the block time to retire any sample that released nothing.
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_half(input half_t hw);
    settle();
    cfg_if.valid      <= 1'b1;
    cfg_if.half_width <= hw;
    do @(posedge clk); while (!cfg_if.ready);
    half_cfg = hw;
    n_half_wr++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one sample word, wait for it to be taken, and queue what it should
  // release: typed-in words where the row gives them, else the predictor's.
  task automatic send_sample(input sample_t s, input logic l, input int n_typed,
                             input sample_t t0, input sample_t t1);
    stream_if.valid       <= 1'b1;
    stream_if.sample      <= s;
    stream_if.last_sample <= l;
    do @(posedge clk); while (!stream_if.ready);
    advance_filter(s, l);
    if (n_typed == PREDICT) begin
      foreach (released[i]) median_q.insert(median_q.size(), released[i]);
    end else begin
      median_q.insert(median_q.size(), '{t0, l && n_typed == 1});
      if (n_typed == 2) median_q.insert(median_q.size(), '{t1, l});
    end
    n_samples++;
    if (l) n_streams++;
    @(negedge clk);
  endtask

  // Sender pacing: bursts of back-to-back words with random gaps between;
  // now and then a long burst gives a stretch with no gaps at all.
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  function automatic sample_t pick_value(input value_style_t style);
    value_style_t s;
    s = style;
    if (s == VAL_MIXED) s = value_style_t'($urandom_range(0, 2));
    case (s)
      VAL_NARROW: return sample_t'($urandom_range(0, 15));
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Receiver: now and then switch between free-flowing, choppy and long-stall
  // patterns, so that stalls meet the output stage of the block at random points.
  rx_mode_t rx_mode  = RX_FREE;
  int       rx_left  = 0;
  int       rx_stall = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE: begin
          result_if.ready <= 1'b1;
        end
        RX_CHOPPY: begin
          result_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (rx_stall > 0) begin
            result_if.ready <= 1'b0;
            rx_stall--;
          end else begin
            result_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 24);
          end
        end
      endcase
    end
  end

  // Compare every word that leaves the block against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (median_q.size() == 0) begin
        $error("unexpected word: median_value %h, last_result %0b",
               result_if.median_value, result_if.last_result);
        err_cnt++;
      end else begin
        got = median_q.pop_front();
        words_seen++;
        if (result_if.median_value !== got.median) begin
          $error("median_value: expected %h, actual %h", got.median,
                 result_if.median_value);
          err_cnt++;
        end
        if (result_if.last_result !== got.last) begin
          $error("last_result: expected %0b, actual %0b", got.last,
                 result_if.last_result);
          err_cnt++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t    row;
    value_style_t style;
    int           len;
    int           n_random;
    logic         ends_stream;

    rst                   = 1'b1;
    stream_if.valid       = 1'b0;
    stream_if.sample      = '0;
    stream_if.last_sample = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.half_width     = '0;
    result_if.ready       = 1'b0;
    foreach (win_hist[i]) win_hist[i] = '0;
    held_cnt   = '0;
    owed_cnt   = '0;
    half_cfg   = half_t'(HALF_RESET);
    burst_left = $urandom_range(1, 8);
    n_random   = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table first.
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_HALF) begin
        write_half(row.half);
      end else begin
        send_sample(row.smp, row.last, row.n_typed, row.typed0, row.typed1);
        pace();
      end
    end

    // Random streams: random length and content style, some long enough to
    // fill the history. Most end with a last word; the rest stay open so the
    // next half-width write lands mid-stream.
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        write_half(half_t'($urandom_range(0, 7)));
      end else if ($urandom_range(0, 3) == 0) begin
        settle();
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20)
                                        : $urandom_range(1, 10);
      style       = value_style_t'($urandom_range(0, 3));
      ends_stream = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        send_sample(pick_value(style), ends_stream && k == len - 1, PREDICT,
                    '0, '0);
        n_random++;
        pace();
      end
    end
    // Close whatever stream is still open so every owed median comes out.
    send_sample(pick_value(VAL_WIDE), 1'b1, PREDICT, '0, '0);

    settle();

    $display("Run covered %0d sample words in %0d streams with %0d half-width writes;",
             n_samples, n_streams, n_half_wr);
    $display("%0d median words were checked against the predictor.", words_seen);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
